>>> design/raycast_column_setup_macros.svh
// ----------------------------------------------------------------------------
// raycast_column_setup_macros: assertion helpers
// Small macros for the concurrent checks of the column setup block.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_SETUP_MACROS_SVH
`define RAYCAST_COLUMN_SETUP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg: column setup shared types
// Payload structs and fixed formats for the column setup block.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_W     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_H     = 2'd2;

    // map tile edge in map units; a power of two so the modulo is a mask
    localparam int unsigned TILE_UNITS = 64;

    typedef struct packed {
        logic [23:0]        hit_distance;
        logic signed [15:0] view_ray_angle;
        logic [23:0]        hit_x;
        logic [23:0]        hit_y;
        logic [1:0]         wall_face;
    } t_col_req;

    typedef struct packed {
        logic [23:0] wall_size;
        logic [10:0] top_row;
        logic [10:0] bottom_row;
        logic [11:0] texel_column;
        logic [23:0] texel_step;
        logic [31:0] texel_start;
    } t_col_res;

    // quarter-turn cosine polynomial, q14 in and out
    function automatic logic [14:0] quarter_cos(input logic [14:0] z);
        logic signed [31:0] z2;
        logic signed [47:0] p;
        begin
            z2 = (32'(z) * 32'(z)) >>> 14;
            p  = 48'sd15;
            p  = 48'sd342   - ((p * 48'(z2)) >>> 14);
            p  = 48'sd4156  - ((p * 48'(z2)) >>> 14);
            p  = 48'sd20213 - ((p * 48'(z2)) >>> 14);
            p  = 48'sd16384 - ((p * 48'(z2)) >>> 14);
            if (p < 48'sd0) begin
                p = 48'sd0;
            end
            if (p > 48'sd16384) begin
                p = 48'sd16384;
            end
            quarter_cos = p[14:0];
        end
    endfunction

endpackage

>>> design/rcs_if.sv
// ----------------------------------------------------------------------------
// rcs_if: valid/ready channel
// Generic handshake channel carrying one payload type.
// ----------------------------------------------------------------------------
interface rcs_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/rcs_div.sv
// ----------------------------------------------------------------------------
// rcs_div: pipelined restoring divider
// One quotient bit per stage; side data travels with each operand pair.
// ----------------------------------------------------------------------------
module rcs_div #(
    parameter int unsigned NUM_W  = 48,
    parameter int unsigned DEN_W  = 24,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);
    localparam int unsigned REM_W = DEN_W + 1;

    logic [NUM_W:0]      r_vld;
    logic [NUM_W-1:0]    r_num  [NUM_W+1];
    logic [REM_W-1:0]    r_rem  [NUM_W+1];
    logic [DEN_W-1:0]    r_den  [NUM_W+1];
    logic [SIDE_W-1:0]   r_side [NUM_W+1];

    assign r_vld[0]  = i_valid;
    assign r_num[0]  = i_num;
    assign r_rem[0]  = '0;
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [REM_W:0]   n_trial;
        logic [REM_W-1:0] n_rem;
        logic [NUM_W-1:0] n_num;
        always_comb begin
            n_trial = {r_rem[s], r_num[s][NUM_W-1]};
            if (n_trial >= (REM_W+1)'(r_den[s])) begin
                n_rem = REM_W'(n_trial - (REM_W+1)'(r_den[s]));
                n_num = {r_num[s][NUM_W-2:0], 1'b1};
            end else begin
                n_rem = REM_W'(n_trial);
                n_num = {r_num[s][NUM_W-2:0], 1'b0};
            end
        end
        logic             r_v;
        logic [NUM_W-1:0] r_n;
        logic [REM_W-1:0] r_r;
        logic [DEN_W-1:0] r_d;
        logic [SIDE_W-1:0] r_sd;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= r_vld[s];
            end
            if (i_en) begin
                r_n  <= n_num;
                r_r  <= n_rem;
                r_d  <= r_den[s];
                r_sd <= r_side[s];
            end
        end
        assign r_vld[s+1]  = r_v;
        assign r_num[s+1]  = r_n;
        assign r_rem[s+1]  = r_r;
        assign r_den[s+1]  = r_d;
        assign r_side[s+1] = r_sd;
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quot  = r_num[NUM_W];
    assign o_side  = r_side[NUM_W];
endmodule

>>> design/raycast_column_setup.sv
// ----------------------------------------------------------------------------
// raycast_column_setup: per-column wall setup
// Fisheye correction, wall height, screen rows and texture mapping per ray.
// ----------------------------------------------------------------------------
//  channel   dir  payload      role
//  s_req     in   t_col_req    one ray hit per request
//  m_res     out  t_col_res    one wall slice per request
//  cfg       in   idx/data     projection distance, texture size
//
// one request enters per cycle while the pipe is not halted; two 48-stage
// bit-per-stage dividers (wall height, then texel step) sit in series with
// five single register stages around them.
// the whole pipe advances together; it halts only when the output register
// is full and not taken, so a stall neither drops nor repeats a request.
// synchronous active-low reset clears valid bits and loads register defaults.
`include "raycast_column_setup_macros.svh"

module raycast_column_setup #(
    parameter int unsigned SCREEN_ROWS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rcs_if.sink                           s_req,
    rcs_if.source                         m_res,
    input  logic                          i_cfg_we,
    input  logic [rcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned TILE_Q8_W = $clog2(rcs_pkg::TILE_UNITS * 256);
    localparam logic [37:0] HALF_Q8   = 38'((SCREEN_ROWS / 2) * 256);
    localparam logic [12:0] ROWS      = 13'(SCREEN_ROWS);
    localparam int unsigned SIDE1_W   = 12;
    localparam int unsigned SIDE2_W   = 24 + 12 + 11 + 11 + 25;

    // configuration registers
    logic [19:0] r_proj;
    logic [12:0] r_tex_w;
    logic [12:0] r_tex_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj  <= 20'd227023;
            r_tex_w <= 13'd64;
            r_tex_h <= 13'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcs_pkg::CFG_PROJ_DIST: r_proj  <= i_cfg_data;
                rcs_pkg::CFG_TEX_W:     r_tex_w <= i_cfg_data[12:0];
                rcs_pkg::CFG_TEX_H:     r_tex_h <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // global advance: output slot free or being drained
    logic w_en;
    logic r_out_vld;
    assign w_en        = !r_out_vld || m_res.ready;
    assign s_req.ready = w_en;

    // quarter-turn cosine table, one entry per 64 angle units
    logic [14:0] w_cos_tab [256];
    for (genvar j = 0; j < 256; j++) begin : g_cos_tab
        assign w_cos_tab[j] = rcs_pkg::quarter_cos(15'(j * 64));
    end

    // fold the angle into a quarter turn; the mirrored index wraps to a
    // quarter turn exactly when the low index is zero, where the cosine is 0
    logic [7:0]         w_cos_j;
    logic [7:0]         w_cos_jm;
    logic [14:0]        w_cos_r;
    logic [14:0]        w_cos_rc;
    logic signed [15:0] w_cos;
    assign w_cos_j  = s_req.data.view_ray_angle[13:6];
    assign w_cos_jm = 8'd0 - w_cos_j;
    assign w_cos_r  = w_cos_tab[w_cos_j];
    assign w_cos_rc = (w_cos_j == 8'd0) ? 15'd0 : w_cos_tab[w_cos_jm];

    always_comb begin
        unique case (s_req.data.view_ray_angle[15:14])
            2'd0:    w_cos = $signed({1'b0, w_cos_r});
            2'd1:    w_cos = -$signed({1'b0, w_cos_rc});
            2'd2:    w_cos = -$signed({1'b0, w_cos_r});
            default: w_cos = $signed({1'b0, w_cos_rc});
        endcase
    end

    // stage a: cosine lookup, texture coordinate select
    logic             r_a_vld;
    logic [23:0]      r_a_dist;
    logic signed [15:0] r_a_cos;
    logic [TILE_Q8_W-1:0] r_a_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_req.valid;
        end
        if (w_en) begin
            r_a_dist  <= s_req.data.hit_distance;
            r_a_cos   <= w_cos;
            r_a_coord <= (s_req.data.wall_face < 2'd2)
                ? s_req.data.hit_x[TILE_Q8_W-1:0] : s_req.data.hit_y[TILE_Q8_W-1:0];
        end
    end

    // stage b: distance times cosine, coordinate times texture width
    logic        r_b_vld;
    logic [38:0] r_b_prod;
    logic        r_b_pos;
    logic [11:0] r_b_col;
    logic [TILE_Q8_W+12:0] w_colp;
    assign w_colp = (TILE_Q8_W+13)'(r_a_coord) * (TILE_Q8_W+13)'(r_tex_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
        if (w_en) begin
            r_b_prod <= 39'(r_a_dist) * 39'(r_a_cos[14:0]);
            r_b_pos  <= r_a_cos > 16'sd0;
            r_b_col  <= 12'(w_colp >> TILE_Q8_W);
        end
    end

    // stage c: corrected distance, wall height numerator
    logic [24:0] w_cd_raw;
    logic [24:0] w_cd;
    logic [47:0] w_num1;
    assign w_cd_raw = r_b_pos ? r_b_prod[38:14] : 25'd0;
    assign w_cd     = (w_cd_raw == 25'd0) ? 25'd1 : w_cd_raw;
    assign w_num1   = 48'(r_proj) * 48'(rcs_pkg::TILE_UNITS) * 48'd256;

    logic              w_d1_vld;
    logic [47:0]       w_q1;
    logic [SIDE1_W-1:0] w_s1;
    rcs_div #(.NUM_W(48), .DEN_W(25), .SIDE_W(SIDE1_W)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_vld),
        .i_num   (w_num1),
        .i_den   (w_cd),
        .i_side  (r_b_col),
        .o_valid (w_d1_vld),
        .o_quot  (w_q1),
        .o_side  (w_s1)
    );

    // stage d: saturate height, rows, start offset
    logic        r_d_vld;
    logic [23:0] r_d_h;
    logic [11:0] r_d_col;
    logic [10:0] r_d_top;
    logic [10:0] r_d_bot;
    logic [24:0] r_d_rel;
    logic [23:0] w_h;
    logic [37:0] w_top_q8;
    logic [37:0] w_bot_q8;
    logic [37:0] w_top_row;
    logic [37:0] w_bot_row;
    logic [37:0] w_rel;
    always_comb begin
        w_h       = (w_q1 > 48'hFFFFFF) ? 24'hFFFFFF : w_q1[23:0];
        w_top_q8  = HALF_Q8 - 38'(w_h[23:1]);
        w_top_row = (HALF_Q8 < 38'(w_h[23:1])) ? 38'd0 : (w_top_q8 >> 8);
        w_bot_q8  = HALF_Q8 + 38'(w_h[23:1]);
        w_bot_row = w_bot_q8 >> 8;
        if (w_bot_row > 38'(ROWS)) begin
            w_bot_row = 38'(ROWS);
        end
        w_rel = (w_top_row << 8) + 38'(w_h[23:1]) - HALF_Q8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= w_d1_vld;
        end
        if (w_en) begin
            r_d_h   <= w_h;
            r_d_col <= w_s1;
            r_d_top <= w_top_row[10:0];
            r_d_bot <= w_bot_row[10:0];
            // rel is positive only when the wall runs past the top of the screen
            r_d_rel <= (w_rel[37] || w_rel == 38'd0) ? 25'd0 : w_rel[24:0];
        end
    end

    // texel step divider
    logic              w_d2_vld;
    logic [47:0]       w_q2;
    logic [SIDE2_W-1:0] w_s2;
    logic [47:0]       w_num2;
    assign w_num2 = 48'(r_tex_h) << 24;
    rcs_div #(.NUM_W(48), .DEN_W(24), .SIDE_W(SIDE2_W)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_vld),
        .i_num   (w_num2),
        .i_den   (r_d_h),
        .i_side  ({r_d_h, r_d_col, r_d_top, r_d_bot, r_d_rel}),
        .o_valid (w_d2_vld),
        .o_quot  (w_q2),
        .o_side  (w_s2)
    );

    logic [23:0] w_e_h;
    logic [11:0] w_e_col;
    logic [10:0] w_e_top;
    logic [10:0] w_e_bot;
    logic [24:0] w_e_rel;
    assign w_e_h   = w_s2[SIDE2_W-1 -: 24];
    assign w_e_col = w_s2[58:47];
    assign w_e_top = w_s2[46:36];
    assign w_e_bot = w_s2[35:25];
    assign w_e_rel = w_s2[24:0];

    // stage e: saturate step
    logic        r_e_vld;
    logic [23:0] r_e_step;
    logic [23:0] r_e_h;
    logic [11:0] r_e_col;
    logic [10:0] r_e_top;
    logic [10:0] r_e_bot;
    logic [24:0] r_e_rel;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= w_d2_vld;
        end
        if (w_en) begin
            r_e_step <= (w_e_h == 24'd0 || w_q2 > 48'hFFFFFF) ? 24'hFFFFFF : w_q2[23:0];
            r_e_h    <= w_e_h;
            r_e_col  <= w_e_col;
            r_e_top  <= w_e_top;
            r_e_bot  <= w_e_bot;
            r_e_rel  <= w_e_rel;
        end
    end

    // stage f: start = rel * step / 256, into output register
    logic [40:0] w_start;
    assign w_start = 41'((49'(r_e_rel) * 49'(r_e_step)) >> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_e_vld;
        end
        if (w_en) begin
            m_res.data.wall_size    <= r_e_h;
            m_res.data.top_row      <= r_e_top;
            m_res.data.bottom_row   <= r_e_bot;
            m_res.data.texel_column <= r_e_col;
            m_res.data.texel_step   <= r_e_step;
            m_res.data.texel_start  <= (|w_start[40:32]) ? 32'hFFFFFFFF : w_start[31:0];
        end
    end
    assign m_res.valid = r_out_vld;

    // checks
    `RCS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, r_out_vld && !m_res.ready,
        r_out_vld && $stable(m_res.data), "result changed while stalled")
    `RCS_ASSERT_IMPL(a_rows_order, i_clk, i_rst_n, r_out_vld,
        m_res.data.top_row <= m_res.data.bottom_row, "top row below bottom row")
    `RCS_ASSERT_IMPL(a_bot_clamp, i_clk, i_rst_n, r_out_vld,
        m_res.data.bottom_row <= 11'(ROWS), "bottom row beyond screen")
endmodule
